[hw/rtl/fct_pkg.sv]
// ---------------------------------------------------------------------------
// fct_pkg
// Types, codes and a helper function shared by the flow connection tracker.
// ---------------------------------------------------------------------------
package fct_pkg;

  localparam int FCT_ENTRIES   = 64;
  localparam int FCT_TICK_BITS = 32;
  localparam int FCT_KEY_W     = 48;

  typedef enum logic [1:0] {
    MODE_INBOUND  = 2'd0,
    MODE_OUTBOUND = 2'd1,
    MODE_LOOKUP   = 2'd2
  } fct_mode_t;

  typedef enum logic [1:0] {
    PROTO_TCP = 2'd0,
    PROTO_UDP = 2'd1
  } fct_proto_t;

  typedef enum logic [3:0] {
    CS_NONE       = 4'd0,
    CS_SYN        = 4'd1,
    CS_SYN_RCVD   = 4'd2,
    CS_ESTAB      = 4'd3,
    CS_FIN_WAIT   = 4'd4,
    CS_CLOSE_WAIT = 4'd5,
    CS_LAST_ACK   = 4'd6,
    CS_TIME_WAIT  = 4'd7,
    CS_CLOSE      = 4'd8,
    CS_UDP        = 4'd9,
    CS_UDP_STREAM = 4'd10
  } fct_conn_state_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY,
    FSM_DONE
  } fct_fsm_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  protocol;
    logic [31:0] src_addr;
    logic [15:0] src_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_port;
    logic        flag_syn;
    logic        flag_fin;
    logic        flag_rst;
    logic        flag_ack;
    logic [31:0] now_tick;
  } fct_in_t;

  typedef struct packed {
    logic        hit;
    logic        table_full;
    logic        ignored;
    logic [3:0]  flow_state;
    logic [31:0] orig_dst_addr;
    logic [15:0] orig_dst_port;
  } fct_out_t;

  // One stored flow, less its time stamp.
  typedef struct packed {
    logic [FCT_KEY_W-1:0] key;
    fct_conn_state_t      conn_state;
    logic [FCT_KEY_W-1:0] orig_dst;
  } fct_rec_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } fct_mem_cmd_t;

  // TCP flag handling; SYN beats FIN beats RST beats ACK.
  function automatic fct_conn_state_t tcp_next(fct_conn_state_t s, logic outbound,
                                               logic syn, logic fin, logic rst_f,
                                               logic ack);
    fct_conn_state_t r;
    r = s;
    if (syn) begin
      if (outbound) r = (s == CS_SYN_RCVD) ? CS_ESTAB : CS_SYN;
      else          r = (s == CS_SYN) ? CS_ESTAB : CS_SYN_RCVD;
    end else if (fin) begin
      if (outbound) r = (s == CS_CLOSE_WAIT) ? CS_LAST_ACK : CS_FIN_WAIT;
      else          r = (s == CS_FIN_WAIT) ? CS_TIME_WAIT : CS_CLOSE_WAIT;
    end else if (rst_f) begin
      r = CS_CLOSE;
    end else if (ack) begin
      if (outbound) r = (s == CS_LAST_ACK) ? CS_CLOSE : CS_ESTAB;
      else          r = (s == CS_TIME_WAIT) ? s : CS_ESTAB;
    end
    return r;
  endfunction

endpackage

[hw/rtl/fct_table.sv]
// ---------------------------------------------------------------------------
// fct_table
// Flow table storage: one record memory and one time stamp memory, sharing
// a single address, with registered read data.
// ---------------------------------------------------------------------------
module fct_table #(
  parameter int ENTRIES   = fct_pkg::FCT_ENTRIES,
  parameter int TICK_BITS = fct_pkg::FCT_TICK_BITS
) (
  input  logic                         clk,
  input  fct_pkg::fct_mem_cmd_t        cmd,
  input  logic [$clog2(ENTRIES)-1:0]   addr,
  input  fct_pkg::fct_rec_t            wr_rec,
  input  logic [TICK_BITS-1:0]         wr_tick,
  output fct_pkg::fct_rec_t            rd_rec
);
  import fct_pkg::*;

  fct_rec_t             rec_mem  [ENTRIES];
  logic [TICK_BITS-1:0] tick_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      rec_mem[addr]  <= wr_rec;
      tick_mem[addr] <= wr_tick;
    end
    if (cmd.rd_en) begin
      rd_rec <= rec_mem[addr];
    end
  end

endmodule

[hw/rtl/fct_ctrl.sv]
// ---------------------------------------------------------------------------
// fct_ctrl
// Sequencer: walks the filled part of the table one entry a cycle through a
// shared key comparator, then answers a lookup, or updates or allocates one flow.
// ---------------------------------------------------------------------------
module fct_ctrl #(
  parameter int ENTRIES   = fct_pkg::FCT_ENTRIES,
  parameter int TICK_BITS = fct_pkg::FCT_TICK_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  fct_pkg::fct_in_t             item,
  input  logic                         out_free,
  output logic                         res_load,
  output fct_pkg::fct_out_t            res,
  output fct_pkg::fct_mem_cmd_t        cmd,
  output logic [$clog2(ENTRIES)-1:0]   addr,
  output fct_pkg::fct_rec_t            wr_rec,
  output logic [TICK_BITS-1:0]         wr_tick,
  input  fct_pkg::fct_rec_t            rd_rec
);
  import fct_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  fct_fsm_t          state, state_next;
  fct_in_t           cur, cur_next;
  fct_out_t          res_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  scan_idx, scan_idx_next;
  logic [IDX_W-1:0]  pend_idx, pend_idx_next;
  logic              pend, pend_next;
  logic              found, found_next;

  logic [FCT_KEY_W-1:0] key;
  logic                 match;
  logic                 outbound;
  logic                 table_is_full;
  fct_conn_state_t      old_state, new_state;
  logic [FCT_KEY_W-1:0] old_orig, new_orig;

  // Inbound packets key on the destination pair, all else on the source pair.
  assign key = (cur.mode == MODE_INBOUND) ? {cur.dst_addr, cur.dst_port}
                                          : {cur.src_addr, cur.src_port};
  assign match         = pend && (rd_rec.key == key);
  assign outbound      = (cur.mode == MODE_OUTBOUND);
  assign table_is_full = (count == CNT_W'(ENTRIES));
  assign item_ready    = (state == FSM_IDLE);

  always_comb begin
    old_state = found ? rd_rec.conn_state : CS_NONE;
    old_orig  = found ? rd_rec.orig_dst : '0;
    if (cur.protocol == PROTO_TCP) begin
      new_state = tcp_next(old_state, outbound, cur.flag_syn, cur.flag_fin,
                           cur.flag_rst, cur.flag_ack);
    end else begin
      new_state = (old_state == CS_UDP) ? CS_UDP_STREAM : CS_UDP;
    end
    new_orig = outbound ? {cur.dst_addr, cur.dst_port} : old_orig;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    res      <= res_next;
    scan_idx <= scan_idx_next;
    pend_idx <= pend_idx_next;
    found    <= found_next;
  end

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    res_next      = res;
    count_next    = count;
    scan_idx_next = scan_idx;
    pend_idx_next = pend_idx;
    pend_next     = pend;
    found_next    = found;
    cmd           = '0;
    addr          = scan_idx[IDX_W-1:0];
    wr_rec        = '{key: key, conn_state: new_state, orig_dst: new_orig};
    wr_tick       = TICK_BITS'(cur.now_tick);
    res_load      = 1'b0;

    case (state)
      FSM_IDLE: begin
        if (item_valid) begin
          cur_next      = item;
          res_next      = '0;
          scan_idx_next = '0;
          pend_next     = 1'b0;
          found_next    = 1'b0;
          case (item.mode)
            MODE_INBOUND, MODE_OUTBOUND: begin
              if (item.protocol inside {PROTO_TCP, PROTO_UDP}) begin
                state_next = (count == '0) ? FSM_APPLY : FSM_SCAN;
              end else begin
                res_next.ignored = 1'b1;
                state_next       = FSM_DONE;
              end
            end
            MODE_LOOKUP: begin
              state_next = (count == '0) ? FSM_APPLY : FSM_SCAN;
            end
            default: begin
              state_next = FSM_DONE;
            end
          endcase
        end
      end

      // Reads are issued back to back; the entry read last cycle is compared
      // while the next one is fetched. Keys are unique, so the first match
      // is the only one.
      FSM_SCAN: begin
        if (match) begin
          found_next = 1'b1;
          pend_next  = 1'b0;
          state_next = FSM_APPLY;
        end else if (scan_idx < count) begin
          cmd.rd_en     = 1'b1;
          pend_next     = 1'b1;
          pend_idx_next = scan_idx[IDX_W-1:0];
          scan_idx_next = scan_idx + CNT_W'(1);
        end else begin
          pend_next  = 1'b0;
          state_next = FSM_APPLY;
        end
      end

      FSM_APPLY: begin
        state_next = FSM_DONE;
        if (cur.mode == MODE_LOOKUP) begin
          if (found) begin
            res_next.hit           = 1'b1;
            res_next.flow_state    = rd_rec.conn_state;
            res_next.orig_dst_addr = rd_rec.orig_dst[47:16];
            res_next.orig_dst_port = rd_rec.orig_dst[15:0];
          end
        end else if (!found && table_is_full) begin
          res_next.table_full = 1'b1;
        end else begin
          cmd.wr_en              = 1'b1;
          addr                   = found ? pend_idx : count[IDX_W-1:0];
          count_next             = found ? count : count + CNT_W'(1);
          res_next.hit           = found;
          res_next.flow_state    = new_state;
          res_next.orig_dst_addr = new_orig[47:16];
          res_next.orig_dst_port = new_orig[15:0];
        end
      end

      FSM_DONE: begin
        if (out_free) begin
          res_load   = 1'b1;
          state_next = FSM_IDLE;
        end
      end

      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("fill count beyond table depth");

  a_write_only_in_apply: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_en |-> (state == FSM_APPLY) && !cmd.rd_en)
    else $error("table written outside the update step");

  a_count_grows_on_alloc: assert property (@(posedge clk) disable iff (rst)
    !(cmd.wr_en && !found) |=> count == $past(count))
    else $error("fill count moved without an allocation");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> state != FSM_IDLE)
    else $error("accepted word did not start the sequencer");

endmodule

[hw/rtl/flow_connection_tracker_top.sv]
// ---------------------------------------------------------------------------
// flow_connection_tracker_top
// Flow connection tracker: table of TCP/UDP flows keyed by address and port.
// ---------------------------------------------------------------------------
// One word is processed at a time. The single read port of the flow table
// feeds a shared 48-bit key comparator with one entry per cycle, so a packet
// or lookup word is compared against the N flows currently stored, where N
// is 1 to ENTRIES, before its result is loaded into the output register;
// the scan stops early at a matching flow, and with an empty table there is
// no scan. A packet with an unknown protocol or a word with an unused mode
// skips the table. The input is ready again the cycle after the load, so a
// new word is only accepted once the last result is loaded, which waits
// while a finished result cannot leave a full output register. Flows are
// placed in order and never evicted, so a fill count cleared at reset marks
// the live entries; there is no clearing pass. The next word is taken while
// a finished result still waits in the output register.
module flow_connection_tracker_top #(
  parameter int ENTRIES   = fct_pkg::FCT_ENTRIES,
  parameter int TICK_BITS = fct_pkg::FCT_TICK_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  fct_pkg::fct_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output fct_pkg::fct_out_t result
);
  import fct_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  fct_mem_cmd_t         cmd;
  logic [IDX_W-1:0]     addr;
  fct_rec_t             wr_rec;
  fct_rec_t             rd_rec;
  logic [TICK_BITS-1:0] wr_tick;
  fct_out_t             res;
  logic                 res_load;
  logic                 out_free;

  assign out_free = !result_valid || result_ready;

  fct_ctrl #(
    .ENTRIES   (ENTRIES),
    .TICK_BITS (TICK_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_free   (out_free),
    .res_load   (res_load),
    .res        (res),
    .cmd        (cmd),
    .addr       (addr),
    .wr_rec     (wr_rec),
    .wr_tick    (wr_tick),
    .rd_rec     (rd_rec)
  );

  fct_table #(
    .ENTRIES   (ENTRIES),
    .TICK_BITS (TICK_BITS)
  ) u_table (
    .clk     (clk),
    .cmd     (cmd),
    .addr    (addr),
    .wr_rec  (wr_rec),
    .wr_tick (wr_tick),
    .rd_rec  (rd_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res;
    end
  end

endmodule

[bench/flow_connection_tracker_top_tb.sv]
// ---------------------------------------------------------------------------
// flow_connection_tracker_top_tb
// Self-checking bench for the flow connection tracker. A scoreboard keeps its
// own copy of the flow table and predicts the result of every accepted word.
// Stimulus runs from directed corner cases through TCP handshakes, UDP bursts
// and noise, and on to filling the table. Both sides idle in random bursts,
// and the result side holds off once long enough to back up the input.
// ---------------------------------------------------------------------------
module flow_connection_tracker_top_tb;
  import fct_pkg::*;

  class flow_table_scoreboard;
    logic [FCT_KEY_W-1:0] flow_key   [FCT_ENTRIES];
    fct_conn_state_t      flow_state [FCT_ENTRIES];
    logic [FCT_KEY_W-1:0] flow_dst   [FCT_ENTRIES];
    logic [31:0]          flow_tick  [FCT_ENTRIES];
    int                   flows_used;
    fct_out_t             flow_results_due[$];
    int                   n_bad;
    int                   n_checked;
    int                   n_hit;
    int                   n_full;
    int                   n_ignored;

    function new();
      flows_used = 0;
      n_bad      = 0;
      n_checked  = 0;
      n_hit      = 0;
      n_full     = 0;
      n_ignored  = 0;
    endfunction

    function int find_flow(logic [FCT_KEY_W-1:0] k);
      for (int i = 0; i < flows_used; i++)
        if (flow_key[i] == k) return i;
      return -1;
    endfunction

    // SYN takes priority over FIN, then RST, then ACK.
    function fct_conn_state_t tcp_advance(fct_conn_state_t s, bit outb, logic [3:0] fl);
      logic syn;
      logic fin;
      logic rs;
      logic ack;
      {syn, fin, rs, ack} = fl;
      if (syn) begin
        if (outb) return (s == CS_SYN_RCVD) ? CS_ESTAB : CS_SYN;
        return (s == CS_SYN) ? CS_ESTAB : CS_SYN_RCVD;
      end
      if (fin) begin
        if (outb) return (s == CS_CLOSE_WAIT) ? CS_LAST_ACK : CS_FIN_WAIT;
        return (s == CS_FIN_WAIT) ? CS_TIME_WAIT : CS_CLOSE_WAIT;
      end
      if (rs) return CS_CLOSE;
      if (ack) begin
        if (outb) return (s == CS_LAST_ACK) ? CS_CLOSE : CS_ESTAB;
        return (s == CS_TIME_WAIT) ? s : CS_ESTAB;
      end
      return s;
    endfunction

    function void note_word(fct_in_t w);
      fct_out_t             o;
      logic [FCT_KEY_W-1:0] k;
      int                   slot;
      bit                   outb;
      fct_conn_state_t      s;
      o = '0;
      if (w.mode == MODE_LOOKUP) begin
        slot = find_flow({w.src_addr, w.src_port});
        if (slot >= 0) begin
          o.hit = 1'b1;
          o.flow_state = flow_state[slot];
          {o.orig_dst_addr, o.orig_dst_port} = flow_dst[slot];
        end
      end else if (w.mode == MODE_INBOUND || w.mode == MODE_OUTBOUND) begin
        outb = (w.mode == MODE_OUTBOUND);
        if (w.protocol != PROTO_TCP && w.protocol != PROTO_UDP) begin
          o.ignored = 1'b1;
        end else begin
          k = outb ? {w.src_addr, w.src_port} : {w.dst_addr, w.dst_port};
          slot = find_flow(k);
          if (slot >= 0) begin
            o.hit = 1'b1;
          end else if (flows_used < FCT_ENTRIES) begin
            // Flows are never evicted, so the lowest free slot is the fill count.
            slot = flows_used;
            flows_used++;
            flow_key[slot]   = k;
            flow_state[slot] = CS_NONE;
            flow_dst[slot]   = '0;
            flow_tick[slot]  = '0;
          end
          if (slot < 0) begin
            o.table_full = 1'b1;
          end else begin
            s = flow_state[slot];
            if (w.protocol == PROTO_TCP)
              s = tcp_advance(s, outb, {w.flag_syn, w.flag_fin, w.flag_rst, w.flag_ack});
            else
              s = (s == CS_UDP) ? CS_UDP_STREAM : CS_UDP;
            flow_state[slot] = s;
            if (outb) flow_dst[slot] = {w.dst_addr, w.dst_port};
            flow_tick[slot] = w.now_tick;
            o.flow_state = s;
            {o.orig_dst_addr, o.orig_dst_port} = flow_dst[slot];
          end
        end
      end
      flow_results_due.push_back(o);
    endfunction

    function void check_result(fct_out_t r);
      fct_out_t e;
      if (flow_results_due.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result word: hit=%0b full=%0b ign=%0b st=%0d dst=%h:%h",
                   r.hit, r.table_full, r.ignored, r.flow_state,
                   r.orig_dst_addr, r.orig_dst_port);
        return;
      end
      e = flow_results_due.pop_front();
      n_checked++;
      if (e.hit) n_hit++;
      if (e.table_full) n_full++;
      if (e.ignored) n_ignored++;
      if (r.hit !== e.hit || r.table_full !== e.table_full || r.ignored !== e.ignored ||
          r.flow_state !== e.flow_state || r.orig_dst_addr !== e.orig_dst_addr ||
          r.orig_dst_port !== e.orig_dst_port) begin
        n_bad++;
        if (n_bad <= 10) begin
          $display("mismatch on result %0d:", n_checked);
          $display("  expected hit=%0b full=%0b ign=%0b st=%0d dst=%h:%h",
                   e.hit, e.table_full, e.ignored, e.flow_state,
                   e.orig_dst_addr, e.orig_dst_port);
          $display("  actual   hit=%0b full=%0b ign=%0b st=%0d dst=%h:%h",
                   r.hit, r.table_full, r.ignored, r.flow_state,
                   r.orig_dst_addr, r.orig_dst_port);
        end
      end
    endfunction
  endclass

  localparam logic [1:0] MODE_UNUSED    = 2'd3;
  localparam logic [1:0] PROTO_OTHER    = 2'd2;
  localparam logic [1:0] PROTO_RESERVED = 2'd3;

  // Flag masks, ordered {syn, fin, rst, ack}.
  localparam logic [3:0] F_NONE = 4'b0000;
  localparam logic [3:0] F_SYN  = 4'b1000;
  localparam logic [3:0] F_FIN  = 4'b0100;
  localparam logic [3:0] F_RST  = 4'b0010;
  localparam logic [3:0] F_ACK  = 4'b0001;
  localparam logic [3:0] F_ALL  = 4'b1111;

  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_WORDS  = 60;

  logic     clk;
  logic     rst;
  logic     item_valid;
  logic     item_ready;
  fct_in_t  item;
  logic     result_valid;
  logic     result_ready;
  fct_out_t result;

  flow_table_scoreboard sb = new();

  fct_in_t stim_q[$];
  int      n_directed;
  bit      tx_idle;
  bit      rx_idle;
  bit      hold_go;
  bit      hold_done;

  flow_connection_tracker_top u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [FCT_KEY_W-1:0] rand_key();
    return {$urandom(), 16'($urandom())};
  endfunction

  function automatic void push_word(logic [1:0] mode, logic [1:0] proto,
                                    logic [FCT_KEY_W-1:0] src,
                                    logic [FCT_KEY_W-1:0] dst, logic [3:0] fl);
    fct_in_t w;
    w.mode = mode;
    w.protocol = proto;
    {w.src_addr, w.src_port} = src;
    {w.dst_addr, w.dst_port} = dst;
    {w.flag_syn, w.flag_fin, w.flag_rst, w.flag_ack} = fl;
    w.now_tick = $urandom();
    stim_q.push_back(w);
  endfunction

  // An outbound packet carries the flow key as its source, an inbound one as
  // its destination; the other pair is random.
  function automatic void push_pkt(logic [1:0] mode, logic [1:0] proto,
                                   logic [FCT_KEY_W-1:0] k, logic [3:0] fl);
    if (mode == MODE_OUTBOUND) push_word(mode, proto, k, rand_key(), fl);
    else                       push_word(mode, proto, rand_key(), k, fl);
  endfunction

  function automatic void push_lookup(logic [FCT_KEY_W-1:0] k);
    push_word(MODE_LOOKUP, 2'($urandom()), k, rand_key(), 4'($urandom()));
  endfunction

  function automatic logic [1:0] rand_dir();
    return $urandom_range(0, 1) ? MODE_OUTBOUND : MODE_INBOUND;
  endfunction

  function automatic void push_script(int kind, logic [FCT_KEY_W-1:0] k);
    int n;
    case (kind)
      0: begin
        // Active open, some data, active close.
        push_pkt(MODE_OUTBOUND, PROTO_TCP, k, F_SYN);
        push_pkt(MODE_INBOUND, PROTO_TCP, k, F_SYN | F_ACK);
        push_pkt(MODE_OUTBOUND, PROTO_TCP, k, F_ACK);
        n = $urandom_range(0, 2);
        repeat (n) push_pkt(rand_dir(), PROTO_TCP, k, F_ACK);
        push_pkt(MODE_OUTBOUND, PROTO_TCP, k, F_FIN | F_ACK);
        push_pkt(MODE_INBOUND, PROTO_TCP, k, F_FIN | F_ACK);
        push_pkt(MODE_INBOUND, PROTO_TCP, k, F_ACK);
        push_lookup(k);
      end
      1: begin
        // Passive open, passive close.
        push_pkt(MODE_INBOUND, PROTO_TCP, k, F_SYN);
        push_pkt(MODE_OUTBOUND, PROTO_TCP, k, F_SYN | F_ACK);
        push_pkt(MODE_INBOUND, PROTO_TCP, k, F_ACK);
        push_pkt(MODE_INBOUND, PROTO_TCP, k, F_FIN);
        push_pkt(MODE_OUTBOUND, PROTO_TCP, k, F_FIN);
        push_pkt(MODE_OUTBOUND, PROTO_TCP, k, F_ACK);
        push_lookup(k);
      end
      2: begin
        push_pkt(MODE_OUTBOUND, PROTO_TCP, k, F_SYN);
        push_pkt(rand_dir(), PROTO_TCP, k, $urandom_range(0, 1) ? F_RST : (F_RST | F_ACK));
        push_lookup(k);
      end
      default: begin
        n = $urandom_range(1, 4);
        repeat (n) push_pkt(rand_dir(), PROTO_UDP, k, 4'($urandom()));
        push_lookup(k);
      end
    endcase
  endfunction

  function automatic void push_noise(logic [FCT_KEY_W-1:0] k);
    logic [1:0] mode;
    logic [47:0] src;
    logic [47:0] dst;
    mode = 2'($urandom());
    src = rand_key();
    dst = rand_key();
    if ($urandom_range(0, 1)) begin
      if (mode == MODE_INBOUND) dst = k;
      else                      src = k;
    end
    push_word(mode, 2'($urandom()), src, dst, 4'($urandom()));
  endfunction

  function automatic void build_stimulus();
    logic [FCT_KEY_W-1:0] pool[16];
    logic [FCT_KEY_W-1:0] ka;
    logic [FCT_KEY_W-1:0] kb;
    logic [FCT_KEY_W-1:0] kz;
    logic [FCT_KEY_W-1:0] ko;
    int                   r;
    kz = '0;
    ko = '1;
    ka = rand_key();
    kb = rand_key();
    foreach (pool[i]) pool[i] = rand_key();

    // Corner cases: all-zero and all-one keys, misses, ignored words.
    push_word(MODE_LOOKUP, PROTO_RESERVED, ko, ko, F_ALL);
    push_word(MODE_LOOKUP, PROTO_TCP, kz, kz, F_NONE);
    push_word(MODE_INBOUND, PROTO_TCP, kz, ko, F_NONE);
    push_word(MODE_OUTBOUND, PROTO_TCP, kz, ko, F_NONE);
    push_word(MODE_LOOKUP, PROTO_UDP, kz, ko, F_ALL);
    push_word(MODE_INBOUND, PROTO_OTHER, ko, ko, F_ALL);
    push_word(MODE_OUTBOUND, PROTO_RESERVED, kz, kz, F_SYN);
    push_word(MODE_UNUSED, PROTO_TCP, ko, ko, F_ALL);
    // One flow walked through the TCP states.
    push_pkt(MODE_OUTBOUND, PROTO_TCP, ka, F_SYN);
    push_pkt(MODE_INBOUND, PROTO_TCP, ka, F_SYN);
    push_pkt(MODE_OUTBOUND, PROTO_TCP, ka, F_ACK);
    push_pkt(MODE_OUTBOUND, PROTO_TCP, ka, F_FIN);
    push_pkt(MODE_INBOUND, PROTO_TCP, ka, F_FIN);
    push_pkt(MODE_INBOUND, PROTO_TCP, ka, F_ACK);
    push_pkt(MODE_OUTBOUND, PROTO_TCP, ka, F_ACK);
    push_pkt(MODE_INBOUND, PROTO_TCP, ka, F_RST);
    push_pkt(MODE_OUTBOUND, PROTO_TCP, ka, F_ALL);
    // UDP single and stream.
    push_pkt(MODE_OUTBOUND, PROTO_UDP, kb, F_NONE);
    push_pkt(MODE_INBOUND, PROTO_UDP, kb, F_ALL);
    push_pkt(MODE_OUTBOUND, PROTO_UDP, kb, F_SYN);
    push_lookup(kb);
    push_word(MODE_INBOUND, PROTO_TCP, kz, ko, F_FIN);
    push_word(MODE_OUTBOUND, PROTO_TCP, ko, kz, F_FIN);
    push_word(MODE_OUTBOUND, PROTO_TCP, ko, ko, F_ACK);
    n_directed = stim_q.size();

    // Well-formed flows on a small key pool, with some noise.
    while (stim_q.size() < n_directed + 260) begin
      r = $urandom_range(0, 9);
      if (r < 8) push_script($urandom_range(0, 3), pool[$urandom_range(0, 15)]);
      else       push_noise(pool[$urandom_range(0, 15)]);
    end
    // Fresh keys fill the table; later fresh keys must be refused.
    repeat (50) push_pkt(rand_dir(), 2'($urandom_range(0, 1)), rand_key(), 4'($urandom()));
    while (stim_q.size() < n_directed + 520) begin
      r = $urandom_range(0, 9);
      if (r < 4)
        push_pkt(rand_dir(), 2'($urandom_range(0, 1)), rand_key(), 4'($urandom()));
      else if (r < 8)
        push_script($urandom_range(0, 3), pool[$urandom_range(0, 15)]);
      else
        push_noise(pool[$urandom_range(0, 15)]);
    end
  endfunction

  task automatic send_words();
    int n;
    bit ok;
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i % 40 == 0) begin
        tx_idle = ($urandom_range(0, 2) != 0);
        rx_idle = ($urandom_range(0, 2) != 0);
      end
      if (i >= stim_q.size() - TAIL_WORDS) begin
        tx_idle = 1'b0;
        rx_idle = 1'b0;
      end
      if (i == n_directed) hold_go = 1'b1;
      if (tx_idle && $urandom_range(0, 4) == 0) begin
        item_valid <= 1'b0;
        n = $urandom_range(1, 11);
        repeat (n) @(posedge clk);
      end
      item <= stim_q[i];
      item_valid <= 1'b1;
      // Ready is sampled mid-cycle, where it is stable for the coming edge.
      do begin
        @(negedge clk);
        ok = item_ready;
        @(posedge clk);
      end while (!ok);
      sb.note_word(stim_q[i]);
    end
    item_valid <= 1'b0;
  endtask

  initial begin : result_side
    int stall;
    stall = 0;
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      if (stall == 0 && rx_idle && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 11);
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
      end
      @(negedge clk);
      if (!rst && result_valid && result_ready) sb.check_result(result);
    end
  end

  initial begin : watchdog
    #5000000;
    $display("flow_connection_tracker_top_tb: done, errors");
    $finish;
  end

  initial begin : main
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_go = 1'b0;
    hold_done = 1'b0;
    build_stimulus();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    send_words();
    while (sb.flow_results_due.size() != 0) @(posedge clk);
    repeat (FCT_ENTRIES + 16) @(posedge clk);
    $display("run covered %0d words: %0d hits, %0d refused for a full table, %0d ignored",
             sb.n_checked, sb.n_hit, sb.n_full, sb.n_ignored);
    $display("flows stored: %0d of %0d, bad results: %0d",
             sb.flows_used, FCT_ENTRIES, sb.n_bad);
    if (sb.n_bad == 0 && sb.flow_results_due.size() == 0)
      $display("flow_connection_tracker_top_tb: done, clean");
    else
      $display("flow_connection_tracker_top_tb: done, errors");
    $finish;
  end

endmodule
